### rtl/abs_pkg.sv
// Shared types and constants of the anchored binary search unit.
`default_nettype none

package abs_pkg;

   localparam int ENTRY_INDEX_WIDTH  = 8;
   localparam int FIELD_KEY_WIDTH    = 32;
   localparam int COUNT_FIELD_WIDTH  = 9;
   localparam int RESULT_INDEX_WIDTH = 9;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int CSR_DATA_WIDTH     = 9;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   localparam logic [1:0] ANCHOR_ANY   = 2'd0;
   localparam logic [1:0] ANCHOR_FIRST = 2'd1;
   localparam logic [1:0] ANCHOR_LAST  = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TABLE_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPARE_SIGNED = 1'd1;

   typedef struct packed {
      logic                         action;
      logic [ENTRY_INDEX_WIDTH-1:0] entry_index;
      logic [FIELD_KEY_WIDTH-1:0]   entry_value;
      logic [FIELD_KEY_WIDTH-1:0]   search_key;
      logic [1:0]                   anchor_mode;
   } req_payload_type;

   typedef struct packed {
      logic                          found;
      logic [RESULT_INDEX_WIDTH-1:0] result_index;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/anchored_binary_search_unit.sv
// Top level of the anchored binary search unit: register file, sequencer and key table.
// A write transfer is taken in the idle state and does not leave it; the next item is accepted on the following cycle.
// A search runs bisection probes (at most clog2(DEPTH)+2 probes), then an anchor walk
// that steps over equal entries one at a time, then presents the result from a done state.
// Every probe is a read of the key table read port (S_READ) followed by a compare (S_CMP).
// Reset clears the sequencer, the result valid, table_count and compare_signed.
`default_nettype none

module anchored_binary_search_unit
   import abs_pkg::*;
#(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_payload_type            req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_payload_type                 rsp_payload,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int IW = $clog2(DEPTH);

   logic [COUNT_FIELD_WIDTH-1:0] table_count_ff, table_count_in;
   logic                         compare_signed_ff, compare_signed_in;

   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic [IW-1:0]        ram_rd_addr;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      table_count_in    = table_count_ff;
      compare_signed_in = compare_signed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TABLE_COUNT:    table_count_in    = COUNT_FIELD_WIDTH'(csr_wdata);
            CSR_COMPARE_SIGNED: compare_signed_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_count_ff    <= '0;
         compare_signed_ff <= 1'b0;
      end else begin
         table_count_ff    <= table_count_in;
         compare_signed_ff <= compare_signed_in;
      end
   end

   abs_search_fsm #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_search_fsm (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .table_count    (table_count_ff),
      .compare_signed (compare_signed_ff),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   abs_key_ram #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

### rtl/abs_key_ram.sv
// Key table memory with one write port and one registered read port.
`default_nettype none

module abs_key_ram #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32,
   localparam int IW       = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IW-1:0]        wr_addr,
   input  wire logic [KEY_WIDTH-1:0] wr_data,
   input  wire logic [IW-1:0]        rd_addr,
   output logic      [KEY_WIDTH-1:0] rd_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/abs_search_fsm.sv
// Search sequencer: bisection and anchor walk over the key table, result register.
`default_nettype none

module abs_search_fsm
   import abs_pkg::*;
#(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32,
   localparam int IW       = $clog2(DEPTH),
   localparam int CW       = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire req_payload_type               req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rsp_payload_type                    rsp_payload,
   input  wire logic [COUNT_FIELD_WIDTH-1:0]  table_count,
   input  wire logic                          compare_signed,
   output logic                               ram_wr_en,
   output logic      [IW-1:0]                 ram_wr_addr,
   output logic      [KEY_WIDTH-1:0]          ram_wr_data,
   output logic      [IW-1:0]                 ram_rd_addr,
   input  wire logic [KEY_WIDTH-1:0]          ram_rd_data
);

   localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_ANCHOR,
      S_WREAD,
      S_WCMP,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        start_ff, start_in;
   logic [IW-1:0]        end_ff, end_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 sign_ff, sign_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic [CW-1:0]        count_clamped;
   logic [KEY_WIDTH-1:0] entry_key;
   logic                 key_eq;
   logic                 key_gt;
   logic [IW-1:0]        next_start;

   function automatic logic [IW-1:0] midpoint(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[IW:1];
   endfunction

   function automatic logic [KEY_WIDTH-1:0] order_key(input logic [KEY_WIDTH-1:0] v,
                                                      input logic           signed_mode);
      return signed_mode ? (v ^ SIGN_BIT) : v;
   endfunction

   assign count_clamped = (int'(table_count) > DEPTH) ? CW'(DEPTH) : CW'(table_count);
   assign entry_key     = order_key(ram_rd_data, sign_ff);
   assign key_eq        = (key_ff == entry_key);
   assign key_gt        = (key_ff > entry_key);
   assign next_start    = (start_ff == cur_ff) ? cur_ff + IW'(1) : cur_ff;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign ram_rd_addr = cur_ff;
   assign ram_wr_addr = IW'(req_payload.entry_index);
   assign ram_wr_data = KEY_WIDTH'(req_payload.entry_value);

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      cur_in         = cur_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      sign_in        = sign_ff;
      mode_in        = mode_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      ram_wr_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_payload.action == ACTION_WRITE) begin
                  ram_wr_en = (int'(req_payload.entry_index) < DEPTH);
               end else begin
                  key_in   = order_key(KEY_WIDTH'(req_payload.search_key), compare_signed);
                  sign_in  = compare_signed;
                  mode_in  = req_payload.anchor_mode;
                  count_in = count_clamped;
                  found_in = 1'b0;
                  if (count_clamped == '0) begin
                     idx_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     start_in = '0;
                     end_in   = IW'(count_clamped - CW'(1));
                     cur_in   = IW'((count_clamped - CW'(1)) >> 1);
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (cur_ff != end_ff) begin
               priority if (key_eq) begin
                  found_in = 1'b1;
                  idx_in   = CW'(cur_ff);
                  state_in = S_ANCHOR;
               end else if (key_gt) begin
                  start_in = next_start;
                  cur_in   = midpoint(next_start, end_ff);
                  state_in = S_READ;
               end else begin
                  end_in   = cur_ff;
                  cur_in   = midpoint(start_ff, cur_ff);
                  state_in = S_READ;
               end
            end else begin
               priority if (key_eq) begin
                  found_in = 1'b1;
                  idx_in   = CW'(cur_ff);
                  state_in = S_ANCHOR;
               end else if (key_gt) begin
                  idx_in   = count_ff;
                  state_in = S_DONE;
               end else begin
                  idx_in   = CW'(cur_ff);
                  state_in = S_DONE;
               end
            end
         end
         S_ANCHOR: begin
            state_in = S_DONE;
            if (mode_ff == ANCHOR_FIRST && idx_ff != '0) begin
               cur_in   = IW'(idx_ff - CW'(1));
               state_in = S_WREAD;
            end else if (mode_ff == ANCHOR_LAST && idx_ff < count_ff - CW'(1)) begin
               cur_in   = IW'(idx_ff + CW'(1));
               state_in = S_WREAD;
            end
         end
         S_WREAD: begin
            state_in = S_WCMP;
         end
         S_WCMP: begin
            if (key_eq) begin
               idx_in   = CW'(cur_ff);
               state_in = S_ANCHOR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.found        = found_ff;
               rsp_payload_in.result_index = RESULT_INDEX_WIDTH'(idx_ff);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff       <= start_in;
      end_ff         <= end_in;
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      count_ff       <= count_in;
      key_ff         <= key_in;
      sign_ff        <= sign_in;
      mode_ff        <= mode_in;
      found_ff       <= found_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire
